/* rtl/ocsm_pkg.sv */
// Shared types and constants for the oven controller core.
// Used by every module of the block; depends on nothing else.
package ocsm_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned TEMP_W   = 10;
  localparam int unsigned TIME_W   = 9;
  localparam int unsigned PCT_W    = 8;
  localparam int unsigned TPS_W    = 4;
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned PERC_W   = 7;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 10;
  localparam int unsigned DIVR_W   = 9;
  localparam int unsigned PROD_W   = 16;
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_AW     = 1;

  localparam logic [TPS_W-1:0]  TPS_RST      = 4'd5;
  localparam logic [HOLD_W-1:0] HOLD_RST     = 8'd5;
  localparam logic [TEMP_W-1:0] DEF_TEMP_RST = 10'd350;
  localparam logic [TEMP_W-1:0] BROIL_RST    = 10'd500;
  localparam logic [TEMP_W-1:0] BASE_RST     = 10'd300;
  localparam logic [PERC_W-1:0] FIRST_RST    = 7'd87;
  localparam logic [PERC_W-1:0] STEP_RST     = 7'd13;
  localparam logic [TEMP_W-1:0] TEMP_MAX     = 10'd1023;
  localparam logic [TIME_W-1:0] TIME_RST     = 9'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_KNOB   = 3'd0,
    KIND_B3_DN  = 3'd1,
    KIND_B3_UP  = 3'd2,
    KIND_B4_DN  = 3'd3,
    KIND_B4_UP  = 3'd4,
    KIND_TICK   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_KNOB,
    OP_B3_DN,
    OP_B3_UP,
    OP_B4_DN,
    OP_B4_UP,
    OP_TICK,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    PH_SETUP  = 2'd0,
    PH_SELECT = 2'd1,
    PH_COOK   = 2'd2,
    PH_RESET  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MD_BAKE  = 2'd0,
    MD_TOAST = 2'd1,
    MD_BROIL = 2'd2
  } mode_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_TPS   = 3'd0,
    CFG_HOLD  = 3'd1,
    CFG_DEFT  = 3'd2,
    CFG_BROIL = 3'd3,
    CFG_BASE  = 3'd4,
    CFG_FIRST = 3'd5,
    CFG_STEP  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    op_e              op;
    logic [ADC_W-1:0] adc;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/oven_control_state_machine_core.sv */
// Oven controller core: setup, selector, cooking and reset-pending phases.
// The input channel carries one event per transaction (knob change, button
// edge or tick) with the current knob reading; the output channel returns one
// result transaction per input transaction, in order, with the phase, mode,
// selector, time left, temperature, LED bar and heater flags after the event.
// Registers are to be written through the plain write port while the block is
// idle; that rule binds the user, and the block itself does not enforce it.
// A front end classifies events into a two-entry queue; the back end executes
// them one at a time and holds the result in an output register.
// A knob, button or unused event goes from the queue through the idle and
// publish states into the output register.
// A tick goes through a bit-serial divider that takes the tick count modulo
// ticks per second; a cooking second adds a division for the percentage.
// While the receiver stalls, the result holds and the back end waits; the
// front end keeps taking transactions until the queue fills, then stalls.
// Reset loads the register defaults, the setup phase in bake mode with the
// selector on time, and empties the queue and the output register.
module oven_control_state_machine_core #(
  parameter int unsigned COUNTER_WIDTH = 16,
  parameter int unsigned LED_WIDTH     = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ocsm_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [ocsm_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ocsm_pkg::KIND_W-1:0]    kind_i,
  input  logic [ocsm_pkg::ADC_W-1:0]     adc_reading_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     oven_mode_state_o,
  output logic [1:0]                     heat_mode_o,
  output logic                           selector_on_temp_o,
  output logic [ocsm_pkg::TIME_W-1:0]    time_left_o,
  output logic [ocsm_pkg::TEMP_W-1:0]    temperature_now_o,
  output logic [LED_WIDTH-1:0]           led_bar_o,
  output logic                           top_heater_on_o,
  output logic                           bottom_heater_on_o
);

  localparam int unsigned DW = (COUNTER_WIDTH > ocsm_pkg::PROD_W) ?
                               COUNTER_WIDTH : ocsm_pkg::PROD_W;

  ocsm_pkg::q_status_t q_status;
  ocsm_pkg::item_t     push_item, head;
  logic                push, pop;
  logic                div_start, div_done;
  logic [DW-1:0]       div_dividend, div_quo;
  logic [ocsm_pkg::DIVR_W-1:0] div_divisor, div_rem;

  ocsm_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .adc_reading_i (adc_reading_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .item_o        (push_item)
  );

  ocsm_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  ocsm_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  ocsm_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .LED_WIDTH     (LED_WIDTH),
    .DW            (DW)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .head_i             (head),
    .q_status_i         (q_status),
    .pop_o              (pop),
    .div_start_o        (div_start),
    .div_dividend_o     (div_dividend),
    .div_divisor_o      (div_divisor),
    .div_done_i         (div_done),
    .div_quo_i          (div_quo),
    .div_rem_i          (div_rem),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .oven_mode_state_o  (oven_mode_state_o),
    .heat_mode_o        (heat_mode_o),
    .selector_on_temp_o (selector_on_temp_o),
    .time_left_o        (time_left_o),
    .temperature_now_o  (temperature_now_o),
    .led_bar_o          (led_bar_o),
    .top_heater_on_o    (top_heater_on_o),
    .bottom_heater_on_o (bottom_heater_on_o)
  );

endmodule

/* rtl/ocsm_front.sv */
// Front end: accepts input transactions and classifies the event kind.
// Depends on ocsm_pkg; pushes classified items into ocsm_fifo.
module ocsm_front (
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ocsm_pkg::KIND_W-1:0]      kind_i,
  input  logic [ocsm_pkg::ADC_W-1:0]       adc_reading_i,
  input  ocsm_pkg::q_status_t              q_status_i,
  output logic                             push_o,
  output ocsm_pkg::item_t                  item_o
);

  ocsm_pkg::op_e op;

  always_comb begin
    case (kind_i)
      ocsm_pkg::KIND_KNOB:  op = ocsm_pkg::OP_KNOB;
      ocsm_pkg::KIND_B3_DN: op = ocsm_pkg::OP_B3_DN;
      ocsm_pkg::KIND_B3_UP: op = ocsm_pkg::OP_B3_UP;
      ocsm_pkg::KIND_B4_DN: op = ocsm_pkg::OP_B4_DN;
      ocsm_pkg::KIND_B4_UP: op = ocsm_pkg::OP_B4_UP;
      ocsm_pkg::KIND_TICK:  op = ocsm_pkg::OP_TICK;
      default:              op = ocsm_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o  = q_status_i.full;
  assign push_o      = in_valid_i && !q_status_i.full;
  assign item_o.op   = op;
  assign item_o.adc  = adc_reading_i;

endmodule

/* rtl/ocsm_fifo.sv */
// Short queue that decouples the front end from the execution back end.
// Depends on ocsm_pkg for the item type and depth.
module ocsm_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ocsm_pkg::item_t     item_i,
  input  logic                pop_i,
  output ocsm_pkg::item_t     head_o,
  output ocsm_pkg::q_status_t status_o
);

  localparam int unsigned AW = ocsm_pkg::Q_AW;
  localparam logic [AW-1:0] LAST = AW'(ocsm_pkg::Q_DEPTH - 1);
  localparam logic [AW:0] FULLC = (AW + 1)'(ocsm_pkg::Q_DEPTH);

  ocsm_pkg::item_t mem_q [ocsm_pkg::Q_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign do_push = push_i && (cnt_q != FULLC);
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == FULLC);
  assign status_o.empty = (cnt_q == '0);

endmodule

/* rtl/ocsm_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on ocsm_pkg for the divisor width.
module ocsm_div #(
  parameter int unsigned DW = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DW-1:0]                dividend_i,
  input  logic [ocsm_pkg::DIVR_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [DW-1:0]                quo_o,
  output logic [ocsm_pkg::DIVR_W-1:0]  rem_o
);

  localparam int unsigned RW = ocsm_pkg::DIVR_W;
  localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [RW-1:0] rem_q, dsr_q;
  logic [RW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = (shifted >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? diff[RW-1:0] : shifted[RW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/ocsm_back.sv */
// Back end: configuration registers, oven state machine and result register.
// Depends on ocsm_pkg; pops items from ocsm_fifo and drives ocsm_div.
module ocsm_back #(
  parameter int unsigned COUNTER_WIDTH = 16,
  parameter int unsigned LED_WIDTH     = 8,
  parameter int unsigned DW            = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ocsm_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [ocsm_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  ocsm_pkg::item_t                head_i,
  input  ocsm_pkg::q_status_t            q_status_i,
  output logic                           pop_o,
  output logic                           div_start_o,
  output logic [DW-1:0]                  div_dividend_o,
  output logic [ocsm_pkg::DIVR_W-1:0]    div_divisor_o,
  input  logic                           div_done_i,
  input  logic [DW-1:0]                  div_quo_i,
  input  logic [ocsm_pkg::DIVR_W-1:0]    div_rem_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     oven_mode_state_o,
  output logic [1:0]                     heat_mode_o,
  output logic                           selector_on_temp_o,
  output logic [ocsm_pkg::TIME_W-1:0]    time_left_o,
  output logic [ocsm_pkg::TEMP_W-1:0]    temperature_now_o,
  output logic [LED_WIDTH-1:0]           led_bar_o,
  output logic                           top_heater_on_o,
  output logic                           bottom_heater_on_o
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned TW = ocsm_pkg::TIME_W;
  localparam int unsigned MW = ocsm_pkg::TEMP_W;
  localparam int unsigned PW = ocsm_pkg::PCT_W;

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_PCT, S_PUB} state_e;

  state_e state_q;

  logic [ocsm_pkg::TPS_W-1:0]  tps_q;
  logic [ocsm_pkg::HOLD_W-1:0] hold_q;
  logic [MW-1:0]               deft_q, broilt_q, base_q;
  logic [ocsm_pkg::PERC_W-1:0] first_q, step_q;

  ocsm_pkg::phase_e phase_q, phase_d;
  ocsm_pkg::mode_e  mode_q, mode_d;
  logic             sel_q, sel_d;
  logic [TW-1:0]    time_q, time_d, start_q, start_d;
  logic [MW-1:0]    temp_q, temp_d;
  logic [PW-1:0]    thr_q, thr_d, thr_step;
  logic [LED_WIDTH-1:0] led_q, led_d, led_shl;
  logic [CW-1:0]    tick_q, tick_d, press_q, press_d, tick_n, hold_len;
  logic [ocsm_pkg::ADC_W-1:0] adc_q;

  ocsm_pkg::op_e    run_op;
  logic [ocsm_pkg::ADC_W-1:0] run_adc;
  logic             run_second, pct_go;
  logic [7:0]       knob_q4;
  logic [MW:0]      temp_sum;
  logic [TW-1:0]    knob_time;
  logic [CW-1:0]    hold_ext;
  logic [ocsm_pkg::PROD_W-1:0] pct_prod;
  logic [ocsm_pkg::TPS_W-1:0]  per;
  logic             slot_free, cooking;

  logic             out_valid_q;
  logic [1:0]       o_phase_q, o_mode_q;
  logic             o_sel_q, o_top_q, o_bot_q;
  logic [TW-1:0]    o_time_q;
  logic [MW-1:0]    o_temp_q;
  logic [LED_WIDTH-1:0] o_led_q;

  assign run_op     = (state_q == S_MOD) ? ocsm_pkg::OP_TICK : head_i.op;
  assign run_adc    = (state_q == S_MOD) ? adc_q : head_i.adc;
  assign run_second = (state_q == S_MOD);

  assign knob_q4   = run_adc[ocsm_pkg::ADC_W-1:2];
  assign temp_sum  = {1'b0, base_q} + (MW + 1)'(knob_q4);
  assign knob_time = TW'(knob_q4) + TW'(1);
  assign hold_len  = tick_q - press_q;
  assign hold_ext  = CW'(hold_q);
  assign thr_step  = (thr_q > PW'(step_q)) ? thr_q - PW'(step_q) : '0;
  assign led_shl   = {led_q[LED_WIDTH-2:0], 1'b0};
  assign tick_n    = tick_q + 1'b1;
  assign per       = (tps_q == '0) ? ocsm_pkg::TPS_W'(1) : tps_q;
  assign pct_prod  = ({7'b0, time_d} << 6) + ({7'b0, time_d} << 5) + ({7'b0, time_d} << 2);

  always_comb begin
    phase_d = phase_q;
    mode_d  = mode_q;
    sel_d   = sel_q;
    time_d  = time_q;
    temp_d  = temp_q;
    start_d = start_q;
    thr_d   = thr_q;
    led_d   = led_q;
    tick_d  = tick_q;
    press_d = press_q;
    pct_go  = 1'b0;
    case (phase_q)
      ocsm_pkg::PH_SETUP: begin
        if (mode_q == ocsm_pkg::MD_BAKE && sel_q) begin
          temp_d = temp_sum[MW] ? ocsm_pkg::TEMP_MAX : temp_sum[MW-1:0];
        end else begin
          time_d = knob_time;
        end
        if (run_op == ocsm_pkg::OP_B3_DN) begin
          press_d = tick_q;
          phase_d = ocsm_pkg::PH_SELECT;
        end else if (run_op == ocsm_pkg::OP_B4_DN) begin
          press_d = tick_q;
          tick_d  = '0;
          phase_d = ocsm_pkg::PH_COOK;
          start_d = time_d;
          thr_d   = PW'(first_q);
          led_d   = '1;
        end
      end
      ocsm_pkg::PH_SELECT: begin
        if (run_op == ocsm_pkg::OP_B3_UP) begin
          if (hold_len <= hold_ext) begin
            case (mode_q)
              ocsm_pkg::MD_BAKE: mode_d = ocsm_pkg::MD_TOAST;
              ocsm_pkg::MD_TOAST: begin
                temp_d = broilt_q;
                mode_d = ocsm_pkg::MD_BROIL;
              end
              default: begin
                mode_d = ocsm_pkg::MD_BAKE;
                temp_d = deft_q;
                time_d = ocsm_pkg::TIME_RST;
              end
            endcase
          end else begin
            sel_d = !sel_q;
          end
          phase_d = ocsm_pkg::PH_SETUP;
        end
      end
      ocsm_pkg::PH_COOK: begin
        if (run_op == ocsm_pkg::OP_B4_DN) begin
          press_d = tick_q;
          phase_d = ocsm_pkg::PH_RESET;
        end else if (run_second && time_q != '0) begin
          time_d = time_q - 1'b1;
          if (start_q != '0) begin
            pct_go = 1'b1;
          end else if (thr_q != '0) begin
            led_d = led_shl;
            thr_d = thr_step;
          end
        end else if (run_second) begin
          time_d  = start_q;
          led_d   = '0;
          phase_d = ocsm_pkg::PH_SETUP;
        end
      end
      default: begin
        if (run_op == ocsm_pkg::OP_B4_UP) begin
          if (hold_len < hold_ext) begin
            phase_d = ocsm_pkg::PH_COOK;
          end
        end else if (hold_len > hold_ext) begin
          time_d  = start_q;
          led_d   = '0;
          phase_d = ocsm_pkg::PH_SETUP;
        end
      end
    endcase
  end

  assign pop_o = (state_q == S_IDLE) && !q_status_i.empty;

  always_comb begin
    div_start_o    = 1'b0;
    div_dividend_o = DW'(pct_prod);
    div_divisor_o  = start_q;
    if (pop_o && head_i.op == ocsm_pkg::OP_TICK) begin
      div_start_o    = 1'b1;
      div_dividend_o = DW'(tick_n);
      div_divisor_o  = ocsm_pkg::DIVR_W'(per);
    end else if (state_q == S_MOD && div_done_i && div_rem_i == '0 && pct_go) begin
      div_start_o = 1'b1;
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign cooking   = (phase_q == ocsm_pkg::PH_COOK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tps_q       <= ocsm_pkg::TPS_RST;
      hold_q      <= ocsm_pkg::HOLD_RST;
      deft_q      <= ocsm_pkg::DEF_TEMP_RST;
      broilt_q    <= ocsm_pkg::BROIL_RST;
      base_q      <= ocsm_pkg::BASE_RST;
      first_q     <= ocsm_pkg::FIRST_RST;
      step_q      <= ocsm_pkg::STEP_RST;
      phase_q     <= ocsm_pkg::PH_SETUP;
      mode_q      <= ocsm_pkg::MD_BAKE;
      sel_q       <= 1'b0;
      time_q      <= ocsm_pkg::TIME_RST;
      temp_q      <= ocsm_pkg::DEF_TEMP_RST;
      start_q     <= '0;
      thr_q       <= PW'(ocsm_pkg::FIRST_RST);
      led_q       <= '0;
      tick_q      <= '0;
      press_q     <= '0;
      adc_q       <= '0;
      out_valid_q <= 1'b0;
      o_phase_q   <= '0;
      o_mode_q    <= '0;
      o_sel_q     <= 1'b0;
      o_time_q    <= '0;
      o_temp_q    <= '0;
      o_led_q     <= '0;
      o_top_q     <= 1'b0;
      o_bot_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ocsm_pkg::CFG_TPS:   tps_q    <= cfg_wdata_i[ocsm_pkg::TPS_W-1:0];
          ocsm_pkg::CFG_HOLD:  hold_q   <= cfg_wdata_i[ocsm_pkg::HOLD_W-1:0];
          ocsm_pkg::CFG_DEFT:  deft_q   <= cfg_wdata_i[MW-1:0];
          ocsm_pkg::CFG_BROIL: broilt_q <= cfg_wdata_i[MW-1:0];
          ocsm_pkg::CFG_BASE:  base_q   <= cfg_wdata_i[MW-1:0];
          ocsm_pkg::CFG_FIRST: first_q  <= cfg_wdata_i[ocsm_pkg::PERC_W-1:0];
          ocsm_pkg::CFG_STEP:  step_q   <= cfg_wdata_i[ocsm_pkg::PERC_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_PUB && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            adc_q <= head_i.adc;
            case (head_i.op)
              ocsm_pkg::OP_TICK: begin
                tick_q  <= tick_n;
                state_q <= S_MOD;
              end
              ocsm_pkg::OP_NONE: begin
                state_q <= S_PUB;
              end
              default: begin
                phase_q <= phase_d;
                mode_q  <= mode_d;
                sel_q   <= sel_d;
                time_q  <= time_d;
                temp_q  <= temp_d;
                start_q <= start_d;
                thr_q   <= thr_d;
                led_q   <= led_d;
                tick_q  <= tick_d;
                press_q <= press_d;
                state_q <= S_PUB;
              end
            endcase
          end
        end
        S_MOD: begin
          if (div_done_i) begin
            if (div_rem_i == '0) begin
              phase_q <= phase_d;
              mode_q  <= mode_d;
              sel_q   <= sel_d;
              time_q  <= time_d;
              temp_q  <= temp_d;
              start_q <= start_d;
              thr_q   <= thr_d;
              led_q   <= led_d;
              tick_q  <= tick_d;
              press_q <= press_d;
              state_q <= pct_go ? S_PCT : S_PUB;
            end else begin
              state_q <= S_PUB;
            end
          end
        end
        S_PCT: begin
          if (div_done_i) begin
            if (div_quo_i < DW'(thr_q)) begin
              led_q <= led_shl;
              thr_q <= thr_step;
            end
            state_q <= S_PUB;
          end
        end
        default: begin
          if (slot_free) begin
            o_phase_q   <= phase_q;
            o_mode_q    <= mode_q;
            o_sel_q     <= sel_q;
            o_time_q    <= time_q;
            o_temp_q    <= temp_q;
            o_led_q     <= led_q;
            o_top_q     <= cooking && (mode_q == ocsm_pkg::MD_BAKE ||
                                       mode_q == ocsm_pkg::MD_BROIL);
            o_bot_q     <= cooking && (mode_q == ocsm_pkg::MD_BAKE ||
                                       mode_q == ocsm_pkg::MD_TOAST);
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign oven_mode_state_o  = o_phase_q;
  assign heat_mode_o        = o_mode_q;
  assign selector_on_temp_o = o_sel_q;
  assign time_left_o        = o_time_q;
  assign temperature_now_o  = o_temp_q;
  assign led_bar_o          = o_led_q;
  assign top_heater_on_o    = o_top_q;
  assign bottom_heater_on_o = o_bot_q;

endmodule

/* rtl/ocsm_checker.sv */
// Port-level checks for the oven controller core, attached by bind.
// Depends on ocsm_pkg for the phase and mode codes.
module ocsm_checker #(
  parameter int unsigned LED_WIDTH = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  oven_mode_state_o,
  input logic [1:0]                  heat_mode_o,
  input logic [ocsm_pkg::TIME_W-1:0] time_left_o,
  input logic [LED_WIDTH-1:0]        led_bar_o,
  input logic                        top_heater_on_o,
  input logic                        bottom_heater_on_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(time_left_o) &&
    $stable(led_bar_o) && $stable(oven_mode_state_o))
    else $error("Stalled result transaction changed.");

  a_heat_cook: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (top_heater_on_o || bottom_heater_on_o) |->
    oven_mode_state_o == ocsm_pkg::PH_COOK)
    else $error("Heater on outside the cooking phase.");

  a_both_bake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && top_heater_on_o && bottom_heater_on_o |->
    heat_mode_o == ocsm_pkg::MD_BAKE)
    else $error("Both heaters on outside bake mode.");

  a_led_cook: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && led_bar_o != '0 |->
    oven_mode_state_o == ocsm_pkg::PH_COOK || oven_mode_state_o == ocsm_pkg::PH_RESET)
    else $error("LED bar lit while not cooking.");

endmodule

bind oven_control_state_machine_core ocsm_checker #(
  .LED_WIDTH (LED_WIDTH)
) u_ocsm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .oven_mode_state_o  (oven_mode_state_o),
  .heat_mode_o        (heat_mode_o),
  .time_left_o        (time_left_o),
  .led_bar_o          (led_bar_o),
  .top_heater_on_o    (top_heater_on_o),
  .bottom_heater_on_o (bottom_heater_on_o)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for oven_control_state_machine_core: queue-fed driver,
// result monitor and an event-level model of the controller. Depends on ocsm_pkg and the core.
module tb;

  localparam logic [ocsm_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [ocsm_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned MAX_PRINTS = 40;
  localparam int PERCENT_FULL = 100;
  localparam int LONG_COOK_TICKS = 300;

  typedef struct packed {
    logic [ocsm_pkg::KIND_W-1:0] kind;
    logic [ocsm_pkg::ADC_W-1:0]  adc;
  } oven_event_t;

  typedef struct packed {
    ocsm_pkg::phase_e            phase;
    ocsm_pkg::mode_e             mode;
    logic                        sel;
    logic [ocsm_pkg::TIME_W-1:0] tleft;
    logic [ocsm_pkg::TEMP_W-1:0] temp;
    logic [7:0]                  led;
    logic                        top;
    logic                        bottom;
  } oven_view_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [ocsm_pkg::CFG_AW-1:0] cfg_addr_i = '0;
  logic [ocsm_pkg::CFG_DW-1:0] cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [ocsm_pkg::KIND_W-1:0] kind_i = '0;
  logic [ocsm_pkg::ADC_W-1:0]  adc_reading_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [1:0]                  oven_mode_state_o;
  logic [1:0]                  heat_mode_o;
  logic                        selector_on_temp_o;
  logic [ocsm_pkg::TIME_W-1:0] time_left_o;
  logic [ocsm_pkg::TEMP_W-1:0] temperature_now_o;
  logic [7:0]                  led_bar_o;
  logic                        top_heater_on_o;
  logic                        bottom_heater_on_o;

  oven_control_state_machine_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .adc_reading_i      (adc_reading_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .oven_mode_state_o  (oven_mode_state_o),
    .heat_mode_o        (heat_mode_o),
    .selector_on_temp_o (selector_on_temp_o),
    .time_left_o        (time_left_o),
    .temperature_now_o  (temperature_now_o),
    .led_bar_o          (led_bar_o),
    .top_heater_on_o    (top_heater_on_o),
    .bottom_heater_on_o (bottom_heater_on_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  oven_event_t pending_events[$];
  oven_view_t  expected_views[$];
  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  int unsigned n_seconds = 0;
  int unsigned n_shifts = 0;
  int unsigned n_done = 0;
  int unsigned n_aborts = 0;
  int unsigned n_resumes = 0;
  int unsigned n_mode_steps = 0;
  int unsigned n_toggles = 0;

  ocsm_pkg::phase_e            ph_now;
  ocsm_pkg::mode_e             mode_now;
  logic                        sel_temp;
  logic [ocsm_pkg::TIME_W-1:0] secs_left;
  logic [ocsm_pkg::TIME_W-1:0] secs_start;
  logic [ocsm_pkg::TEMP_W-1:0] temp_set;
  logic [ocsm_pkg::PCT_W-1:0]  pct_floor;
  logic [7:0]                  led_now;
  logic [15:0]                 tick_cnt;
  logic [15:0]                 press_tick;

  logic [ocsm_pkg::TPS_W-1:0]  tps_cfg;
  logic [ocsm_pkg::HOLD_W-1:0] hold_cfg;
  logic [ocsm_pkg::TEMP_W-1:0] bake_temp_cfg;
  logic [ocsm_pkg::TEMP_W-1:0] broil_temp_cfg;
  logic [ocsm_pkg::TEMP_W-1:0] temp_base_cfg;
  logic [ocsm_pkg::PERC_W-1:0] pct_first_cfg;
  logic [ocsm_pkg::PERC_W-1:0] pct_step_cfg;

  task automatic reset_oven_model();
    tps_cfg        = ocsm_pkg::TPS_RST;
    hold_cfg       = ocsm_pkg::HOLD_RST;
    bake_temp_cfg  = ocsm_pkg::DEF_TEMP_RST;
    broil_temp_cfg = ocsm_pkg::BROIL_RST;
    temp_base_cfg  = ocsm_pkg::BASE_RST;
    pct_first_cfg  = ocsm_pkg::FIRST_RST;
    pct_step_cfg   = ocsm_pkg::STEP_RST;
    ph_now         = ocsm_pkg::PH_SETUP;
    mode_now       = ocsm_pkg::MD_BAKE;
    sel_temp       = 1'b0;
    secs_left      = ocsm_pkg::TIME_RST;
    temp_set       = ocsm_pkg::DEF_TEMP_RST;
    secs_start     = '0;
    pct_floor      = ocsm_pkg::PCT_W'(ocsm_pkg::FIRST_RST);
    led_now        = '0;
    tick_cnt       = '0;
    press_tick     = '0;
  endtask

  function automatic logic [15:0] hold_len();
    return tick_cnt - press_tick;
  endfunction

  task automatic abort_cook();
    secs_left = secs_start;
    led_now   = '0;
    ph_now    = ocsm_pkg::PH_SETUP;
  endtask

  task automatic run_oven(input logic [ocsm_pkg::KIND_W-1:0] kind,
                          input logic [ocsm_pkg::ADC_W-1:0] adc, input bit sec);
    int knob;
    int pct;
    knob = int'(adc) >> 2;
    case (ph_now)
      ocsm_pkg::PH_SETUP: begin
        if (mode_now == ocsm_pkg::MD_BAKE && sel_temp) begin
          temp_set = (knob + int'(temp_base_cfg) > int'(ocsm_pkg::TEMP_MAX))
                     ? ocsm_pkg::TEMP_MAX
                     : ocsm_pkg::TEMP_W'(knob + int'(temp_base_cfg));
        end else begin
          secs_left = ocsm_pkg::TIME_W'(knob + 1);
        end
        if (kind == ocsm_pkg::KIND_B3_DN) begin
          press_tick = tick_cnt;
          ph_now = ocsm_pkg::PH_SELECT;
        end else if (kind == ocsm_pkg::KIND_B4_DN) begin
          press_tick = tick_cnt;
          tick_cnt = '0;
          ph_now = ocsm_pkg::PH_COOK;
          secs_start = secs_left;
          pct_floor = ocsm_pkg::PCT_W'(pct_first_cfg);
          led_now = '1;
        end
      end
      ocsm_pkg::PH_SELECT: begin
        if (kind == ocsm_pkg::KIND_B3_UP) begin
          if (hold_len() <= 16'(hold_cfg)) begin
            n_mode_steps++;
            case (mode_now)
              ocsm_pkg::MD_BAKE: mode_now = ocsm_pkg::MD_TOAST;
              ocsm_pkg::MD_TOAST: begin
                temp_set = broil_temp_cfg;
                mode_now = ocsm_pkg::MD_BROIL;
              end
              default: begin
                mode_now = ocsm_pkg::MD_BAKE;
                temp_set = bake_temp_cfg;
                secs_left = ocsm_pkg::TIME_RST;
              end
            endcase
          end else begin
            sel_temp = ~sel_temp;
            n_toggles++;
          end
          ph_now = ocsm_pkg::PH_SETUP;
        end
      end
      ocsm_pkg::PH_COOK: begin
        if (kind == ocsm_pkg::KIND_B4_DN) begin
          press_tick = tick_cnt;
          ph_now = ocsm_pkg::PH_RESET;
        end else if (sec && secs_left != '0) begin
          secs_left = secs_left - 1'b1;
          pct = (secs_start != '0) ? (int'(secs_left) * PERCENT_FULL) / int'(secs_start) : 0;
          if (pct < int'(pct_floor)) begin
            led_now = {led_now[6:0], 1'b0};
            pct_floor = (pct_floor > ocsm_pkg::PCT_W'(pct_step_cfg))
                        ? pct_floor - ocsm_pkg::PCT_W'(pct_step_cfg) : '0;
            n_shifts++;
          end
        end else if (sec) begin
          abort_cook();
          n_done++;
        end
      end
      default: begin
        if (kind == ocsm_pkg::KIND_B4_UP) begin
          if (hold_len() < 16'(hold_cfg)) begin
            ph_now = ocsm_pkg::PH_COOK;
            n_resumes++;
          end
        end else if (hold_len() > 16'(hold_cfg)) begin
          abort_cook();
          n_aborts++;
        end
      end
    endcase
  endtask

  task automatic predict_oven(input oven_event_t ev);
    oven_view_t v;
    int per;
    if (ev.kind <= ocsm_pkg::KIND_B4_UP) begin
      run_oven(ev.kind, ev.adc, 1'b0);
    end else if (ev.kind == ocsm_pkg::KIND_TICK) begin
      per = (tps_cfg != '0) ? int'(tps_cfg) : 1;
      tick_cnt = tick_cnt + 1'b1;
      if (int'(tick_cnt) % per == 0) begin
        n_seconds++;
        run_oven(ev.kind, ev.adc, 1'b1);
      end
    end
    v.phase  = ph_now;
    v.mode   = mode_now;
    v.sel    = sel_temp;
    v.tleft  = secs_left;
    v.temp   = temp_set;
    v.led    = led_now;
    v.top    = (ph_now == ocsm_pkg::PH_COOK) &&
               (mode_now == ocsm_pkg::MD_BAKE || mode_now == ocsm_pkg::MD_BROIL);
    v.bottom = (ph_now == ocsm_pkg::PH_COOK) &&
               (mode_now == ocsm_pkg::MD_BAKE || mode_now == ocsm_pkg::MD_TOAST);
    expected_views.push_back(v);
  endtask

  task automatic flag_mismatch(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d %s got %0h expected %0h", checked_cnt, name, got,
                              want));
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    oven_event_t ev;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        ev.kind = kind_i;
        ev.adc  = adc_reading_i;
        predict_oven(ev);
        accepted_cnt++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_events.size() > 0) begin
          ev = pending_events.pop_front();
          kind_i <= ev.kind;
          adc_reading_i <= ev.adc;
          in_valid_i <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    oven_view_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          flag_mismatch("result arrived with no transaction outstanding");
        end else begin
          want = expected_views.pop_front();
          checked_cnt++;
          check_field("oven_mode_state", oven_mode_state_o, want.phase);
          check_field("heat_mode", heat_mode_o, want.mode);
          check_field("selector_on_temp", selector_on_temp_o, want.sel);
          check_field("time_left", time_left_o, want.tleft);
          check_field("temperature_now", temperature_now_o, want.temp);
          check_field("led_bar", led_bar_o, want.led);
          check_field("top_heater_on", top_heater_on_o, want.top);
          check_field("bottom_heater_on", bottom_heater_on_o, want.bottom);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 99) < 20) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                       : $urandom_range(1, 3);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt % 400 == 0) calm = ($urandom_range(0, 3) == 0);
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("cycle limit hit with %0d results outstanding", expected_views.size());
      $display("oven_control_state_machine_core verification failed");
      $finish;
    end
  end

  function automatic logic [ocsm_pkg::ADC_W-1:0] rand_adc();
    return ocsm_pkg::ADC_W'($urandom_range(0, (1 << ocsm_pkg::ADC_W) - 1));
  endfunction

  function automatic logic [ocsm_pkg::ADC_W-1:0] short_adc();
    if ($urandom_range(0, 4) == 0) return rand_adc();
    return ocsm_pkg::ADC_W'($urandom_range(0, 35));
  endfunction

  task automatic send(input logic [ocsm_pkg::KIND_W-1:0] kind,
                      input logic [ocsm_pkg::ADC_W-1:0] adc);
    oven_event_t ev;
    ev.kind = kind;
    ev.adc  = adc;
    pending_events.push_back(ev);
    pushed_cnt++;
    if (kind <= ocsm_pkg::KIND_TICK) items_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send(ocsm_pkg::KIND_TICK, rand_adc());
  endtask

  task automatic send_noise(input int n);
    repeat ($urandom_range(1, n)) send(ocsm_pkg::KIND_W'($urandom_range(0, 7)), rand_adc());
  endtask

  task automatic wait_accepted();
    while (accepted_cnt != pushed_cnt) @(negedge clk_i);
  endtask

  task automatic wait_settled();
    while (accepted_cnt != pushed_cnt || expected_views.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input ocsm_pkg::cfg_idx_e idx, input int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= ocsm_pkg::CFG_DW'(val);
    case (idx)
      ocsm_pkg::CFG_TPS:   tps_cfg = ocsm_pkg::TPS_W'(val);
      ocsm_pkg::CFG_HOLD:  hold_cfg = ocsm_pkg::HOLD_W'(val);
      ocsm_pkg::CFG_DEFT:  bake_temp_cfg = ocsm_pkg::TEMP_W'(val);
      ocsm_pkg::CFG_BROIL: broil_temp_cfg = ocsm_pkg::TEMP_W'(val);
      ocsm_pkg::CFG_BASE:  temp_base_cfg = ocsm_pkg::TEMP_W'(val);
      ocsm_pkg::CFG_FIRST: pct_first_cfg = ocsm_pkg::PERC_W'(val);
      default:             pct_step_cfg = ocsm_pkg::PERC_W'(val);
    endcase
  endtask

  task automatic program_regs(input int tps, hold, deft, broil, base, first, step);
    write_reg(ocsm_pkg::CFG_TPS, tps);
    write_reg(ocsm_pkg::CFG_HOLD, hold);
    write_reg(ocsm_pkg::CFG_DEFT, deft);
    write_reg(ocsm_pkg::CFG_BROIL, broil);
    write_reg(ocsm_pkg::CFG_BASE, base);
    write_reg(ocsm_pkg::CFG_FIRST, first);
    write_reg(ocsm_pkg::CFG_STEP, step);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic directed_events();
    send(ocsm_pkg::KIND_KNOB, '0);
    send(ocsm_pkg::KIND_KNOB, '1);
    send(KIND_SPARE_LO, rand_adc());
    send(KIND_SPARE_HI, rand_adc());
    repeat (3) begin
      send(ocsm_pkg::KIND_B3_DN, rand_adc());
      send(ocsm_pkg::KIND_B3_UP, rand_adc());
    end
    send(ocsm_pkg::KIND_B3_DN, rand_adc());
    send_ticks(int'(ocsm_pkg::HOLD_RST) + 1);
    send(ocsm_pkg::KIND_B3_UP, rand_adc());
    send(ocsm_pkg::KIND_KNOB, '1);
    send(ocsm_pkg::KIND_KNOB, '0);
    send(ocsm_pkg::KIND_B4_DN, '0);
    send(ocsm_pkg::KIND_B4_DN, '0);
    send(ocsm_pkg::KIND_B4_UP, '0);
  endtask

  // Picks the next burst from the phase the model is in, so that most bursts are
  // well-formed button sequences and cooking runs, with some noise mixed in.
  task automatic play_scenario();
    int r;
    int k;
    int hold;
    int per;
    int remaining;
    wait_accepted();
    r = $urandom_range(0, 99);
    hold = int'(hold_cfg);
    per = (tps_cfg != '0) ? int'(tps_cfg) : 1;
    case (ph_now)
      ocsm_pkg::PH_SETUP: begin
        if (r < 15) begin
          repeat ($urandom_range(1, 3)) send(ocsm_pkg::KIND_KNOB, rand_adc());
        end else if (r < 35) begin
          send(ocsm_pkg::KIND_B3_DN, rand_adc());
          k = ($urandom_range(0, 3) == 0) ? hold : $urandom_range(0, (hold < 4) ? hold : 4);
          send_ticks(k);
          send(ocsm_pkg::KIND_B3_UP, rand_adc());
        end else if (r < 45) begin
          send(ocsm_pkg::KIND_B3_DN, rand_adc());
          send_ticks(hold + 1 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3)));
          send(ocsm_pkg::KIND_B3_UP, rand_adc());
        end else if (r < 85) begin
          send(ocsm_pkg::KIND_KNOB, short_adc());
          send(ocsm_pkg::KIND_B4_DN, short_adc());
        end else begin
          send_noise(4);
        end
      end
      ocsm_pkg::PH_SELECT: begin
        if (r < 70) begin
          send_ticks($urandom_range(0, 3));
          send(ocsm_pkg::KIND_B3_UP, rand_adc());
        end else begin
          send_noise(3);
        end
      end
      ocsm_pkg::PH_COOK: begin
        remaining = (int'(secs_left) + 2) * per;
        if (r < 25 || remaining > LONG_COOK_TICKS) begin
          send(ocsm_pkg::KIND_B4_DN, rand_adc());
          if (remaining > LONG_COOK_TICKS) begin
            k = hold + 1;
          end else begin
            case ($urandom_range(0, 3))
              0: k = hold - 1;
              1: k = hold;
              2: k = hold + 1;
              default: k = $urandom_range(0, hold + 3);
            endcase
          end
          send_ticks(k);
          if (remaining <= LONG_COOK_TICKS && $urandom_range(0, 1) == 1) begin
            send(ocsm_pkg::KIND_B4_UP, rand_adc());
          end else begin
            send(ocsm_pkg::KIND_KNOB, rand_adc());
          end
        end else if (r < 35) begin
          send_noise(3);
        end else begin
          send_ticks($urandom_range(1, remaining));
        end
      end
      default: begin
        if (r < 40) begin
          send(ocsm_pkg::KIND_B4_UP, rand_adc());
        end else if (r < 70) begin
          send(ocsm_pkg::KIND_KNOB, rand_adc());
        end else begin
          send_ticks($urandom_range(1, hold + 2));
        end
      end
    endcase
  endtask

  initial begin
    int target;
    reset_oven_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_events();
    target = 250;
    while (items_sent < target) play_scenario();
    for (int s = 0; s < 7; s++) begin
      wait_settled();
      case (s)
        0: program_regs(1, 1, 0, 1023, 768, 100, 1);
        1: program_regs(15, 255, 1023, 0, 0, 0, 100);
        2: program_regs(0, 2, 512, 700, 1023, 127, 127);
        default: begin
          program_regs($urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 127), $urandom_range(0, 127));
        end
      endcase
      target += 215;
      while (items_sent < target) play_scenario();
    end
    wait_settled();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_views.size() != 0) flag_mismatch("results still outstanding at end of run");
    $display("Sent %0d events, checked %0d results in %0d cycles.", items_sent, checked_cnt,
             cycle_cnt);
    $display("Saw %0d seconds, %0d LED shifts, %0d finished cooks, %0d aborts, %0d resumes,",
             n_seconds, n_shifts, n_done, n_aborts, n_resumes);
    $display("%0d mode steps and %0d selector toggles; %0d mismatches.", n_mode_steps,
             n_toggles, error_cnt);
    if (error_cnt == 0) begin
      $display("oven_control_state_machine_core verification clean");
    end else begin
      $display("oven_control_state_machine_core verification failed");
    end
    $finish;
  end

endmodule
